@@ rtl/pirt_pkg.sv @@
// pirt_pkg: shared types and constants for the point-in-region table.
// Used by pirt_cell, pirt_ctrl and point_in_region_table. No dependencies.
package pirt_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int REQ_W           = 3;
  localparam int KIND_W          = 2;
  localparam int IDX_IN_W        = 4;
  localparam int STATUS_W        = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 3'd0,
    REQ_CLEAR = 3'd1,
    REQ_QUERY = 3'd2,
    REQ_READ  = 3'd3,
    REQ_LIST  = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // controller to cell row
  typedef struct packed {
    logic load;   // write the addressed cell from the input item
    logic shift;  // rotate the row by one cell toward cell 0
  } cell_ctl_t;

endpackage

@@ rtl/pirt_cell.sv @@
// pirt_cell: one table slot of the region ring; holds one region.
// Depends on pirt_pkg (cell_ctl_t, KIND_W).
module pirt_cell #(
  parameter int COORD_BITS = pirt_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                        clk,
  input  pirt_pkg::cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]            load_idx,
  input  logic [COORD_BITS-1:0]       load_x,
  input  logic [COORD_BITS-1:0]       load_y,
  input  logic [COORD_BITS-1:0]       load_w,
  input  logic [COORD_BITS-1:0]       load_h,
  input  logic [pirt_pkg::KIND_W-1:0] load_k,
  input  logic [COORD_BITS-1:0]       nbr_x,
  input  logic [COORD_BITS-1:0]       nbr_y,
  input  logic [COORD_BITS-1:0]       nbr_w,
  input  logic [COORD_BITS-1:0]       nbr_h,
  input  logic [pirt_pkg::KIND_W-1:0] nbr_k,
  output logic [COORD_BITS-1:0]       cell_x,
  output logic [COORD_BITS-1:0]       cell_y,
  output logic [COORD_BITS-1:0]       cell_w,
  output logic [COORD_BITS-1:0]       cell_h,
  output logic [pirt_pkg::KIND_W-1:0] cell_k
);

  logic [COORD_BITS-1:0]       x_r, y_r, w_r, h_r;
  logic [pirt_pkg::KIND_W-1:0] k_r;
  logic                        sel;

  assign sel = ctl.load && (load_idx == IDX_W'(CELL_IDX));

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (sel) begin
      x_r <= load_x;
      y_r <= load_y;
      w_r <= load_w;
      h_r <= load_h;
      k_r <= load_k;
    end else if (ctl.shift) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
      w_r <= nbr_w;
      h_r <= nbr_h;
      k_r <= nbr_k;
    end
  end

  assign cell_x = x_r;
  assign cell_y = y_r;
  assign cell_w = w_r;
  assign cell_h = h_r;
  assign cell_k = k_r;

endmodule

@@ rtl/pirt_ctrl.sv @@
// pirt_ctrl: request decode, fill count, scan sequencer and result register.
// Depends on pirt_pkg; looks at the head cell of the pirt_cell ring.
module pirt_ctrl #(
  parameter int MAX_REGIONS = pirt_pkg::MAX_REGIONS_DEF,
  parameter int COORD_BITS  = pirt_pkg::COORD_BITS_DEF,
  parameter int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pirt_pkg::REQ_W-1:0]    in_req_type,
  input  logic [pirt_pkg::KIND_W-1:0]   in_box_kind,
  input  logic [COORD_BITS-1:0]         in_point_x,
  input  logic [COORD_BITS-1:0]         in_point_y,
  input  logic [pirt_pkg::IDX_IN_W-1:0] in_entry_index,
  // head of the ring
  input  logic [COORD_BITS-1:0]         head_x,
  input  logic [COORD_BITS-1:0]         head_y,
  input  logic [COORD_BITS-1:0]         head_w,
  input  logic [COORD_BITS-1:0]         head_h,
  input  logic [pirt_pkg::KIND_W-1:0]   head_k,
  output pirt_pkg::cell_ctl_t           ctl,
  output logic [IDX_W-1:0]              load_idx,
  // result channel
  output logic                          out_strobe,
  output logic                          out_found,
  output logic [COORD_BITS-1:0]         out_hit_width,
  output logic [COORD_BITS-1:0]         out_entry_x,
  output logic [COORD_BITS-1:0]         out_entry_y,
  output logic [COORD_BITS-1:0]         out_entry_width,
  output logic [COORD_BITS-1:0]         out_entry_height,
  output logic [pirt_pkg::KIND_W-1:0]   out_entry_kind,
  output logic [CNT_W-1:0]              out_region_count,
  output logic [pirt_pkg::STATUS_W-1:0] out_status,
  output logic                          out_last
);

  localparam int SUM_W    = COORD_BITS + 1;
  localparam int CMP_W    = (CNT_W > pirt_pkg::IDX_IN_W) ? CNT_W : pirt_pkg::IDX_IN_W;
  localparam int LAST_STEP = MAX_REGIONS - 1;

  pirt_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              step_r, step_nxt;
  pirt_pkg::req_t                req_r;
  logic [COORD_BITS-1:0]         px_r, py_r;
  logic [pirt_pkg::KIND_W-1:0]   kind_r;
  logic [pirt_pkg::IDX_IN_W-1:0] idx_r;

  // held entry: query hit, read capture, or pending list match
  logic                        res_v_r, res_v_nxt;
  logic [COORD_BITS-1:0]       res_x_r, res_y_r, res_w_r, res_h_r;
  logic [COORD_BITS-1:0]       res_x_nxt, res_y_nxt, res_w_nxt, res_h_nxt;
  logic [pirt_pkg::KIND_W-1:0] res_k_r, res_k_nxt;

  logic                        accept, full, step_last, in_range, head_hit, idx_here;

  logic                        emit;
  logic                        o_found, o_last;
  logic [COORD_BITS-1:0]       o_hitw, o_x, o_y, o_w, o_h;
  logic [pirt_pkg::KIND_W-1:0] o_k;
  logic [CNT_W-1:0]            o_cnt;
  pirt_pkg::status_t           o_status;

  logic                          strobe_r, found_r, last_r;
  logic [COORD_BITS-1:0]         hitw_r, ex_r, ey_r, ew_r, eh_r;
  logic [pirt_pkg::KIND_W-1:0]   ek_r;
  logic [CNT_W-1:0]              ocnt_r;
  logic [pirt_pkg::STATUS_W-1:0] ostat_r;

  assign busy      = (state_r != pirt_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_W'(MAX_REGIONS));
  assign step_last = (step_r == IDX_W'(LAST_STEP));
  assign in_range  = (CMP_W'(step_r) < CMP_W'(count_r));
  assign idx_here  = (CMP_W'(step_r) == CMP_W'(idx_r));
  assign load_idx  = count_r[IDX_W-1:0];

  // x <= px < x+w and y <= py < y+h, sums one bit wider
  assign head_hit = (head_x <= px_r) &&
                    (SUM_W'(px_r) < SUM_W'(head_x) + SUM_W'(head_w)) &&
                    (head_y <= py_r) &&
                    (SUM_W'(py_r) < SUM_W'(head_y) + SUM_W'(head_h));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pirt_pkg::ST_IDLE: begin
        if (accept && (in_req_type == pirt_pkg::REQ_QUERY ||
                       in_req_type == pirt_pkg::REQ_READ ||
                       in_req_type == pirt_pkg::REQ_LIST)) begin
          state_nxt = pirt_pkg::ST_SCAN;
        end
      end
      pirt_pkg::ST_SCAN: begin
        if (step_last) begin
          state_nxt = pirt_pkg::ST_DONE;
        end
      end
      pirt_pkg::ST_DONE: state_nxt = pirt_pkg::ST_IDLE;
      default:           state_nxt = pirt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    step_nxt  = step_r;
    res_v_nxt = res_v_r;
    res_x_nxt = res_x_r;
    res_y_nxt = res_y_r;
    res_w_nxt = res_w_r;
    res_h_nxt = res_h_r;
    res_k_nxt = res_k_r;
    emit      = 1'b0;
    o_found   = 1'b0;
    o_hitw    = '0;
    o_x       = '0;
    o_y       = '0;
    o_w       = '0;
    o_h       = '0;
    o_k       = '0;
    o_cnt     = count_r;
    o_status  = pirt_pkg::STAT_OK;
    o_last    = 1'b1;
    unique case (state_r)
      pirt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (pirt_pkg::req_t'(in_req_type)) inside
            pirt_pkg::REQ_ADD: begin
              emit = 1'b1;
              if (full) begin
                o_status = pirt_pkg::STAT_FULL;
              end else begin
                ctl.load  = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
              o_cnt = count_nxt;
            end
            pirt_pkg::REQ_CLEAR: begin
              emit      = 1'b1;
              count_nxt = '0;
              o_cnt     = '0;
            end
            pirt_pkg::REQ_QUERY, pirt_pkg::REQ_READ, pirt_pkg::REQ_LIST: begin
              step_nxt  = '0;
              res_v_nxt = 1'b0;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      pirt_pkg::ST_SCAN: begin
        ctl.shift = 1'b1;
        step_nxt  = step_r + IDX_W'(1);
        case (req_r)
          pirt_pkg::REQ_QUERY: begin
            if (in_range && !res_v_r && head_hit) begin
              res_v_nxt = 1'b1;
              res_w_nxt = head_w;
            end
          end
          pirt_pkg::REQ_READ: begin
            if (in_range && idx_here) begin
              res_v_nxt = 1'b1;
              res_x_nxt = head_x;
              res_y_nxt = head_y;
              res_w_nxt = head_w;
              res_h_nxt = head_h;
              res_k_nxt = head_k;
            end
          end
          pirt_pkg::REQ_LIST: begin
            if (in_range && head_k == kind_r) begin
              // a later match exists, so the held one is not the last
              if (res_v_r) begin
                emit    = 1'b1;
                o_found = 1'b1;
                o_x     = res_x_r;
                o_y     = res_y_r;
                o_w     = res_w_r;
                o_h     = res_h_r;
                o_k     = res_k_r;
                o_last  = 1'b0;
              end
              res_v_nxt = 1'b1;
              res_x_nxt = head_x;
              res_y_nxt = head_y;
              res_w_nxt = head_w;
              res_h_nxt = head_h;
              res_k_nxt = head_k;
            end
          end
          default: ;
        endcase
      end
      pirt_pkg::ST_DONE: begin
        emit = 1'b1;
        case (req_r)
          pirt_pkg::REQ_QUERY: begin
            o_found = res_v_r;
            o_hitw  = res_v_r ? res_w_r : '0;
          end
          pirt_pkg::REQ_READ, pirt_pkg::REQ_LIST: begin
            o_found = res_v_r;
            if (res_v_r) begin
              o_x = res_x_r;
              o_y = res_y_r;
              o_w = res_w_r;
              o_h = res_h_r;
              o_k = res_k_r;
            end else if (req_r == pirt_pkg::REQ_READ) begin
              o_status = pirt_pkg::STAT_RANGE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pirt_pkg::ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= emit;
    end
  end

  // request capture, scan state and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= pirt_pkg::req_t'(in_req_type);
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      kind_r <= in_box_kind;
      idx_r  <= in_entry_index;
    end
    step_r  <= step_nxt;
    res_v_r <= res_v_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
    res_w_r <= res_w_nxt;
    res_h_r <= res_h_nxt;
    res_k_r <= res_k_nxt;
    if (emit) begin
      found_r <= o_found;
      hitw_r  <= o_hitw;
      ex_r    <= o_x;
      ey_r    <= o_y;
      ew_r    <= o_w;
      eh_r    <= o_h;
      ek_r    <= o_k;
      ocnt_r  <= o_cnt;
      ostat_r <= o_status;
      last_r  <= o_last;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_found        = found_r;
  assign out_hit_width    = hitw_r;
  assign out_entry_x      = ex_r;
  assign out_entry_y      = ey_r;
  assign out_entry_width  = ew_r;
  assign out_entry_height = eh_r;
  assign out_entry_kind   = ek_r;
  assign out_region_count = ocnt_r;
  assign out_status       = ostat_r;
  assign out_last         = last_r;

`ifndef ASSERT_OFF
  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pirt_pkg::ST_DONE) |=> (out_strobe && out_last))
    else $error("scan finished without a final result");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pirt_pkg::ST_SCAN && step_last) |=> (state_r == pirt_pkg::ST_DONE))
    else $error("scan ran past the last cell");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == pirt_pkg::REQ_ADD && full) |=>
      (out_strobe && out_status == pirt_pkg::STAT_FULL && count_r == $past(count_r)))
    else $error("add to a full table not dropped");

  a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (state_r == pirt_pkg::ST_SCAN ||
                                   state_r == pirt_pkg::ST_DONE))
    else $error("non-final result outside a list scan");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !full)
    else $error("load into a full table");
`endif

endmodule

@@ rtl/point_in_region_table.sv @@
// point_in_region_table: top level; ring of pirt_cell slots plus pirt_ctrl.
// Depends on pirt_pkg, pirt_cell, pirt_ctrl.
//
// Usage: present a request with start high; it is taken at a clock edge
// where busy is low. Every result appears for exactly one cycle with
// out_strobe high and cannot be held off, so the receiver must take it
// then. Add, clear and unknown request codes need no pass: the result
// shows in the next cycle and busy stays low, so such items may follow
// back to back. Query, read and list run a full pass around the ring of
// MAX_REGIONS cells: the item is taken, the scan state visits every cell,
// and the done state then registers the final result. Busy is high in
// the scan and done states, so the next item can be taken at the same
// edge as that final result.
// The pass length is set by the ring: the table rotates one cell per
// cycle past a single compare unit at cell 0, and a pass always
// completes so the table returns to its home positions. A list streams
// each match during the pass once a later match is found, and the final
// one, with out_last set, follows the pass; a list with no match gives
// one result with out_found clear. Region entries hold no reset; only
// slots below the fill count are ever looked at.
module point_in_region_table #(
  parameter int MAX_REGIONS = pirt_pkg::MAX_REGIONS_DEF,
  parameter int COORD_BITS  = pirt_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pirt_pkg::REQ_W-1:0]    in_req_type,
  input  logic [COORD_BITS-1:0]         in_box_x,
  input  logic [COORD_BITS-1:0]         in_box_y,
  input  logic [COORD_BITS-1:0]         in_box_width,
  input  logic [COORD_BITS-1:0]         in_box_height,
  input  logic [pirt_pkg::KIND_W-1:0]   in_box_kind,
  input  logic [COORD_BITS-1:0]         in_point_x,
  input  logic [COORD_BITS-1:0]         in_point_y,
  input  logic [pirt_pkg::IDX_IN_W-1:0] in_entry_index,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic [COORD_BITS-1:0]         out_hit_width,
  output logic [COORD_BITS-1:0]         out_entry_x,
  output logic [COORD_BITS-1:0]         out_entry_y,
  output logic [COORD_BITS-1:0]         out_entry_width,
  output logic [COORD_BITS-1:0]         out_entry_height,
  output logic [pirt_pkg::KIND_W-1:0]   out_entry_kind,
  output logic [$clog2(MAX_REGIONS+1)-1:0] out_region_count,
  output logic [pirt_pkg::STATUS_W-1:0] out_status,
  output logic                          out_last
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // per-slot contents; slot 0 is the head seen by the controller
  logic [COORD_BITS-1:0]       slot_x [MAX_REGIONS];
  logic [COORD_BITS-1:0]       slot_y [MAX_REGIONS];
  logic [COORD_BITS-1:0]       slot_w [MAX_REGIONS];
  logic [COORD_BITS-1:0]       slot_h [MAX_REGIONS];
  logic [pirt_pkg::KIND_W-1:0] slot_k [MAX_REGIONS];

  pirt_pkg::cell_ctl_t ctl;
  logic [IDX_W-1:0]    load_idx;

  // ring: each slot takes its upper neighbor on a shift, the top slot
  // takes the head, so MAX_REGIONS shifts restore the original order
  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    localparam int NBR = (i + 1) % MAX_REGIONS;
    pirt_cell #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_idx (load_idx),
      .load_x   (in_box_x),
      .load_y   (in_box_y),
      .load_w   (in_box_width),
      .load_h   (in_box_height),
      .load_k   (in_box_kind),
      .nbr_x    (slot_x[NBR]),
      .nbr_y    (slot_y[NBR]),
      .nbr_w    (slot_w[NBR]),
      .nbr_h    (slot_h[NBR]),
      .nbr_k    (slot_k[NBR]),
      .cell_x   (slot_x[i]),
      .cell_y   (slot_y[i]),
      .cell_w   (slot_w[i]),
      .cell_h   (slot_h[i]),
      .cell_k   (slot_k[i])
    );
  end

  pirt_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .COORD_BITS  (COORD_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_box_kind      (in_box_kind),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_entry_index   (in_entry_index),
    .head_x           (slot_x[0]),
    .head_y           (slot_y[0]),
    .head_w           (slot_w[0]),
    .head_h           (slot_h[0]),
    .head_k           (slot_k[0]),
    .ctl              (ctl),
    .load_idx         (load_idx),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_hit_width    (out_hit_width),
    .out_entry_x      (out_entry_x),
    .out_entry_y      (out_entry_y),
    .out_entry_width  (out_entry_width),
    .out_entry_height (out_entry_height),
    .out_entry_kind   (out_entry_kind),
    .out_region_count (out_region_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule
